// ===== hw/rtl/nsr_pkg.sv =====
// Shared types and constants for the Newton square root block.
package nsr_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int RAD_W         = 32;
	localparam int ROOT_W        = 24;
	localparam int STEPS_W       = 6;
	localparam int TOL_W         = 16;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 1'b1;

	localparam logic [STEPS_W-1:0] MAX_ITER_RST  = 6'd32;
	localparam logic [TOL_W-1:0]   TOLERANCE_RST = 16'd1;
	localparam logic [ROOT_W-1:0]  ROOT_MAX      = 24'hFFFFFF;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_START = 6'b000010,
		S_DIV   = 6'b000100,
		S_UPD   = 6'b001000,
		S_CHK   = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	typedef struct packed {
		logic               load;
		logic               div_start;
		logic               update;
		logic               out_load;
		logic [STEPS_W-1:0] steps;
	} cmd_t;

	typedef struct packed {
		logic zero_in;
		logic div_done;
		logic close;
	} status_t;

endpackage

// ===== hw/rtl/nsr_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module nsr_div #(
	parameter int DW = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic [DW-1:0] quotient,
	output logic          done
);
	localparam int CW = $clog2(DW + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [DW:0]   shifted;
	logic [DW:0]   trial;
	logic          ge;

	assign shifted = {rem_q, quo_q[DW-1]};
	assign ge      = shifted >= {1'b0, divisor};
	assign trial   = shifted - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(DW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? trial[DW-1:0] : shifted[DW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== hw/rtl/nsr_dp.sv =====
// Datapath: radicand, estimate, divider, convergence test and result register.
module nsr_dp #(
	parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [nsr_pkg::RAD_W-1:0]     radicand,
	input  logic [nsr_pkg::TOL_W-1:0]     tolerance,
	input  nsr_pkg::cmd_t                 cmd,
	output nsr_pkg::status_t              status,
	output logic [nsr_pkg::ROOT_W-1:0]    root,
	output logic [nsr_pkg::STEPS_W-1:0]   steps_used,
	output logic                          converged
);
	import nsr_pkg::*;

	localparam int DW = RAD_W + FRAC_BITS;
	localparam logic [DW-1:0] EST_ONE = DW'(1) << FRAC_BITS;

	logic [DW-1:0]      scaled_q;
	logic [DW-1:0]      est_q;
	logic [DW-1:0]      prev_q;
	logic               conv_q;
	logic [ROOT_W-1:0]  root_q;
	logic [STEPS_W-1:0] steps_q;
	logic               oconv_q;
	logic [DW-1:0]      divisor;
	logic [DW-1:0]      quotient;
	logic               div_done;
	logic [DW:0]        sum;
	logic [DW-1:0]      diff;

	assign divisor = (est_q == '0) ? DW'(1) : est_q;
	assign sum     = {1'b0, est_q} + {1'b0, quotient};
	assign diff    = (prev_q >= est_q) ? (prev_q - est_q) : (est_q - prev_q);

	nsr_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (scaled_q),
		.divisor  (divisor),
		.quotient (quotient),
		.done     (div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			scaled_q <= {radicand, {FRAC_BITS{1'b0}}};
			est_q    <= (radicand == '0) ? '0 : EST_ONE;
			prev_q   <= '0;
			conv_q   <= 1'b1;
		end else if (cmd.update) begin
			prev_q <= est_q;
			est_q  <= sum[DW:1];
		end
		if (cmd.out_load) begin
			root_q  <= (est_q > DW'(ROOT_MAX)) ? ROOT_MAX : est_q[ROOT_W-1:0];
			steps_q <= cmd.steps;
			oconv_q <= conv_q;
		end
		if (status.close && !cmd.load && !cmd.update && !cmd.out_load && !cmd.div_start) begin
			conv_q <= 1'b1;
		end else if (!cmd.load && !cmd.update && !cmd.out_load && !cmd.div_start) begin
			conv_q <= 1'b0;
		end
	end

	assign status.zero_in  = (radicand == '0);
	assign status.div_done = div_done;
	assign status.close    = (diff <= DW'(tolerance));

	assign root       = root_q;
	assign steps_used = steps_q;
	assign converged  = oconv_q;

endmodule

// ===== hw/rtl/nsr_ctrl.sv =====
// Controller state machine that sequences the Newton steps and the handshakes.
module nsr_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	output logic                        out_valid,
	input  logic                        out_ready,
	input  logic [nsr_pkg::STEPS_W-1:0] max_iterations,
	input  nsr_pkg::status_t            status,
	output nsr_pkg::cmd_t               cmd
);
	import nsr_pkg::*;

	state_t             state_q;
	state_t             state_d;
	logic [STEPS_W-1:0] steps_q;
	logic [STEPS_W-1:0] cap;
	logic               out_valid_q;
	logic               slot_free;

	assign cap       = (max_iterations == '0) ? STEPS_W'(1) : max_iterations;
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d       = state_q;
		cmd.load      = 1'b0;
		cmd.div_start = 1'b0;
		cmd.update    = 1'b0;
		cmd.out_load  = 1'b0;
		cmd.steps     = steps_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = status.zero_in ? S_FIN : S_START;
				end
			end
			S_START: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				if (status.div_done) begin
					state_d = S_UPD;
				end
			end
			S_UPD: begin
				cmd.update = 1'b1;
				state_d    = S_CHK;
			end
			S_CHK: begin
				if (status.close || steps_q >= cap) begin
					state_d = S_FIN;
				end else begin
					state_d = S_START;
				end
			end
			S_FIN: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			steps_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				steps_q <= '0;
			end else if (cmd.update) begin
				steps_q <= steps_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/newton_square_root_top.sv =====
// Top level of the Newton square root block with its configuration registers.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    radicand
// out      output     out_valid / out_ready  root, steps_used, converged
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A zero radicand skips the Newton steps and goes straight to the finish state.
// Otherwise each Newton step runs the one-bit-per-cycle restoring divider, updates the
// estimate and tests convergence, for up to max_iterations steps (at least one).
// All control state is cleared by the asynchronous reset; the configuration returns to
// a tolerance of 1 and an iteration cap of 32.
// A result held by a stalled output blocks only the next result, not the next transaction.
module newton_square_root_top #(
	parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [nsr_pkg::RAD_W-1:0]      radicand,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [nsr_pkg::ROOT_W-1:0]     root,
	output logic [nsr_pkg::STEPS_W-1:0]    steps_used,
	output logic                           converged,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [nsr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nsr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import nsr_pkg::*;

	logic [TOL_W-1:0]   tolerance_q;
	logic [STEPS_W-1:0] max_iter_q;
	cmd_t               cmd;
	status_t            status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= TOLERANCE_RST;
			max_iter_q  <= MAX_ITER_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TOLERANCE: tolerance_q <= cfg_data[TOL_W-1:0];
				CFG_MAX_ITER:  max_iter_q  <= cfg_data[STEPS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	nsr_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.max_iterations (max_iter_q),
		.status         (status),
		.cmd            (cmd)
	);

	nsr_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.radicand   (radicand),
		.tolerance  (tolerance_q),
		.cmd        (cmd),
		.status     (status),
		.root       (root),
		.steps_used (steps_used),
		.converged  (converged)
	);

endmodule
